// ----- src/rmf_pkg.sv -----
`default_nettype none

package rmf_pkg;

	localparam int SampleWidth = 16;

	typedef logic signed [SampleWidth-1:0] sample_t;

	// Values that every cell of the sorted row sees in the same cycle.
	typedef struct packed {
		logic    shift;    // an item is accepted this cycle
		sample_t vn;       // incoming sample
		sample_t vo;       // sample that leaves the window
		logic    low_del;  // leaving sample sorts at or below the incoming one
	} rmf_bcast_t;

endpackage

`default_nettype wire

// ----- src/rmf_cell.sv -----
`default_nettype none

// One slot of the sorted window. The row is kept in ascending order, with equal
// values ordered oldest first. On each item the oldest entry drops out, the
// incoming sample is placed after all entries that are not greater than it,
// and every cell between the two positions takes its neighbor's contents.
module rmf_cell import rmf_pkg::*; #(
	parameter int WINDOW = 20,
	parameter int INDEX = 0,
	localparam int AGE_W = $clog2(WINDOW)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  rmf_bcast_t       bc,
	input  sample_t          left_val,
	input  logic [AGE_W-1:0] left_age,
	input  logic             left_gt,
	input  sample_t          right_val,
	input  logic [AGE_W-1:0] right_age,
	input  logic             right_gt,
	output sample_t          val,
	output logic [AGE_W-1:0] age,
	output logic             gt,
	output logic             del
);

	localparam logic [AGE_W-1:0] AgeMax   = AGE_W'(WINDOW - 1);
	localparam logic [AGE_W-1:0] AgeReset = AGE_W'(WINDOW - 1 - INDEX);
	localparam logic [AGE_W-1:0] AgeOne   = AGE_W'(1);

	sample_t          val_q;
	logic [AGE_W-1:0] age_q;
	sample_t          val_d;
	logic [AGE_W-1:0] age_d;
	logic             after_del;
	logic             at_or_after_del;
	logic             at_or_before_del;

	assign val = val_q;
	assign age = age_q;
	assign gt  = val_q > bc.vn;
	assign del = age_q == AgeMax;

	// Position of this cell relative to the leaving entry. Among equal values
	// the leaving entry is the oldest and therefore the first.
	assign after_del        = (val_q > bc.vo) || ((val_q == bc.vo) && !del);
	assign at_or_after_del  = after_del || del;
	assign at_or_before_del = !after_del;

	always_comb begin
		val_d = val_q;
		age_d = age_q + AgeOne;
		if (bc.low_del) begin
			// The gap opens below the insertion point: cells close it from the right.
			if (at_or_after_del && !right_gt) begin
				val_d = right_val;
				age_d = right_age + AgeOne;
			end else if (at_or_after_del && !gt) begin
				val_d = bc.vn;
				age_d = '0;
			end
		end else begin
			// The gap opens above the insertion point: cells close it from the left.
			if (at_or_before_del && left_gt) begin
				val_d = left_val;
				age_d = left_age + AgeOne;
			end else if (at_or_before_del && gt) begin
				val_d = bc.vn;
				age_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AgeReset;
		end else if (bc.shift) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/sliding_window_median_filter.sv -----
`default_nettype none

// Running median filter over the last WINDOW signed 16-bit samples. It takes
// one item per clock cycle, and the median of the window that includes that
// item is on median_out, registered, in the cycle after the item is accepted. The
// rate is set by a row of WINDOW cells that hold the window in sorted order and
// all update in the same cycle: the oldest sample leaves, the new one is
// placed, and the entry at rank WINDOW/2 (the upper median for even WINDOW) is
// the result. The window trails the input, so the median lags the signal by
// WINDOW/2 samples, and after reset the window holds zeros that rank like real
// samples until WINDOW items have arrived. The input stalls only while a result
// is waiting and out_ready is low.
module sliding_window_median_filter import rmf_pkg::*; #(
	parameter int WINDOW = 20
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [SampleWidth-1:0] sample_in,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [SampleWidth-1:0] median_out
);

	localparam int AGE_W = $clog2(WINDOW);
	localparam int MidCell = WINDOW / 2;

	rmf_bcast_t       bc;
	sample_t          vo;
	logic             accept;
	logic             out_valid_q;
	logic [WINDOW-1:0] del_vec;

	// Slot k+1 belongs to cell k; the two ends are fixed borders of the row.
	sample_t          row_val [WINDOW+2];
	logic [AGE_W-1:0] row_age [WINDOW+2];
	logic             row_gt  [WINDOW+2];

	assign row_val[0]        = '0;
	assign row_age[0]        = '0;
	assign row_gt[0]         = 1'b0;
	assign row_val[WINDOW+1] = '0;
	assign row_age[WINDOW+1] = '0;
	assign row_gt[WINDOW+1]  = 1'b1;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Exactly one cell holds the oldest sample; pick its value.
	always_comb begin
		vo = '0;
		for (int k = 0; k < WINDOW; k++) begin
			if (del_vec[k]) begin
				vo = vo | row_val[k+1];
			end
		end
	end

	always_comb begin
		bc.shift   = accept;
		bc.vn      = sample_in;
		bc.vo      = vo;
		bc.low_del = vo <= sample_in;
	end

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		rmf_cell #(
			.WINDOW(WINDOW),
			.INDEX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bc       (bc),
			.left_val (row_val[k]),
			.left_age (row_age[k]),
			.left_gt  (row_gt[k]),
			.right_val(row_val[k+2]),
			.right_age(row_age[k+2]),
			.right_gt (row_gt[k+2]),
			.val      (row_val[k+1]),
			.age      (row_age[k+1]),
			.gt       (row_gt[k+1]),
			.del      (del_vec[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign median_out = row_val[MidCell+1];

	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(del_vec))
		else $error("window does not hold exactly one oldest entry");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while a result is stalled");

	for (genvar k = 0; k < WINDOW - 1; k++) begin : g_chk_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			row_val[k+1] <= row_val[k+2])
			else $error("cell row is out of order");
	end

endmodule

`default_nettype wire

// ----- sim/sliding_window_median_filter_test.sv -----
`default_nettype none

module sliding_window_median_filter_test import rmf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int Window = 20;
	localparam int MedianRank = Window / 2;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample_in = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t median_out;

	// Shadow copy of the window, kept in arrival order.
	sample_t median_window [Window];
	int      next_slot;
	sample_t median_q [$];

	int  error_count;
	int  samples_sent;
	int  medians_seen;
	int  input_stall_cycles;
	int  hold_off_cycles;
	int  stall_left;
	bit  send_idle;
	bit  recv_idle;
	int  trend_value;

	sliding_window_median_filter #(
		.WINDOW(Window)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median_out(median_out)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Rank each entry by counting entries below it and at or below it; an entry
	// whose run of equal values covers the median rank gives the result.
	function automatic sample_t window_median();
		int below;
		int at_or_below;
		for (int i = 0; i < Window; i++) begin
			below = 0;
			at_or_below = 0;
			for (int j = 0; j < Window; j++) begin
				if (median_window[j] < median_window[i]) begin
					below++;
				end
				if (median_window[j] <= median_window[i]) begin
					at_or_below++;
				end
			end
			if (below <= MedianRank && MedianRank < at_or_below) begin
				return median_window[i];
			end
		end
		return '0;
	endfunction

	task automatic report_mismatch(string what, sample_t got, sample_t want);
		$display("ERROR result %0d: %s: got %0d, expected %0d",
			medians_seen, what, got, want);
		error_count++;
	endtask

	// Called at a rising edge; returns at the edge where the item is accepted.
	task automatic send_sample(sample_t value);
		int gap;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		median_window[next_slot] = value;
		next_slot = (next_slot == Window - 1) ? 0 : next_slot + 1;
		median_q.push_back(window_median());
		samples_sent++;
	endtask

	function automatic sample_t clamp_sample(int value);
		if (value > 32767) begin
			return 16'sd32767;
		end else if (value < -32768) begin
			return -16'sd32768;
		end
		return sample_t'(value);
	endfunction

	function automatic sample_t random_sample(int mode);
		case (mode)
			0: return sample_t'($urandom);
			// Few distinct values, so long runs of equal entries.
			1: return sample_t'($urandom_range(0, 4) - 2);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'sd32767;
					1: return -16'sd32768;
					2: return 16'sd0;
					default: return -16'sd1;
				endcase
			end
			3: begin
				trend_value += $urandom_range(0, 800) - 300;
				if (trend_value > 32767 || trend_value < -32768) begin
					trend_value = -trend_value / 2;
				end
				return clamp_sample(trend_value + $urandom_range(0, 64) - 32);
			end
			default: begin
				// Steady level with impulse noise, the usual median use.
				if ($urandom_range(0, 9) == 0) begin
					return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
				end
				return clamp_sample(trend_value + $urandom_range(0, 16) - 8);
			end
		endcase
	endfunction

	// Receiver: a requested hold-off first, otherwise random stalls.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (recv_idle && $urandom_range(0, 99) < 20) begin
				out_ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Both handshakes are sampled at the falling edge, where they are stable.
	always @(negedge clk) begin
		sample_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) begin
				input_stall_cycles++;
			end
			if (out_valid && out_ready) begin
				if (median_q.size() == 0) begin
					report_mismatch("median with none expected", median_out, '0);
				end else begin
					want = median_q.pop_front();
					if (median_out !== want) begin
						report_mismatch("median_out", median_out, want);
					end
				end
				medians_seen++;
			end
		end
	end

	// Zeros from reset take part in the ranking until the window is full.
	task automatic test_startup_extremes();
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd16384);
		send_sample(-16'sd16384);
	endtask

	// Runs of equal values, then enough extremes to wrap the window.
	task automatic test_equal_runs();
		repeat (5) send_sample(16'sd100);
		repeat (5) send_sample(-16'sd100);
		repeat (3) send_sample(16'sd32767);
		repeat (3) send_sample(-16'sd32768);
		send_sample(16'sd0);
		send_sample(16'sd0);
	endtask

	task automatic test_random_stream(int count);
		int mode;
		int left;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				mode = $urandom_range(0, 4);
				left = $urandom_range(10, 80);
				trend_value = $signed(sample_t'($urandom)) / 2;
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
			end
			send_sample(random_sample(mode));
			left--;
		end
	endtask

	// The receiver stops long enough for the block to fill and hold its input.
	task automatic test_output_hold_off();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_off_cycles = 300;
		for (int n = 0; n < 100; n++) begin
			send_sample(random_sample(0));
		end
	endtask

	task automatic test_full_rate(int count);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (int n = 0; n < count; n++) begin
			send_sample(random_sample(n % 5));
		end
	endtask

	initial begin
		for (int i = 0; i < Window; i++) begin
			median_window[i] = '0;
		end
		next_slot = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_extremes();
		test_equal_runs();
		test_random_stream(1550);
		test_output_hold_off();
		test_full_rate(250);

		in_valid <= 1'b0;
		recv_idle = 1'b1;
		while (median_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (5) @(posedge clk);

		$display("Sent %0d samples and checked %0d medians against the window model.",
			samples_sent, medians_seen);
		$display("Input was held off for %0d cycles; %0d mismatches.",
			input_stall_cycles, error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d medians still expected.", median_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
